/* src/palrle_pkg.sv */
// shared types, codes and constants for the palette run-length pixel decoder
// no dependencies
`default_nettype none

package palrle_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned RGB_W             = 24;
  localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR       = 8'h00;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_INDEX = 2'd1,
    MODE_PAIR  = 2'd2,
    MODE_ALPHA = 2'd3
  } mode_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_STREAM = 1'b1
  } op_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_CUT   = 1'b1
  } kind_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] palette_slot;
    logic [7:0] load_red;
    logic [7:0] load_green;
    logic [7:0] load_blue;
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       run_end;
  } out_item_t;

  typedef logic [7:0] cfg_word_t;

  // palette access from the controller
  typedef struct packed {
    logic             wr_en;
    logic [7:0]       wr_slot;
    logic [RGB_W-1:0] wr_rgb;
    logic             rd_en;
    logic [7:0]       rd_slot;
  } pal_req_t;

endpackage

`default_nettype wire

/* src/palrle_chan_if.sv */
// valid/ready channel carrying one payload beat
// payload type is a parameter, normally from palrle_pkg
`default_nettype none

interface palrle_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/palrle_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module palrle_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/palrle_pal.sv */
// palette store: ram plus per-entry valid bits, unwritten or out of range reads black
// depends on palrle_pkg and palrle_ram
`default_nettype none

module palrle_pal #(
  parameter int unsigned DEPTH = palrle_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire palrle_pkg::pal_req_t          req_i,
  output logic [palrle_pkg::RGB_W-1:0]       rgb_o
);
  import palrle_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DEPTH-1:0] valid_q;
  logic             rd_ok_q;
  logic             wr_in_range;
  logic             rd_in_range;
  logic [RGB_W-1:0] ram_rdata;

  assign wr_in_range = ({1'b0, req_i.wr_slot} < 9'(DEPTH));
  assign rd_in_range = ({1'b0, req_i.rd_slot} < 9'(DEPTH));

  palrle_ram #(
    .WIDTH(RGB_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en && wr_in_range),
    .waddr_i(req_i.wr_slot[AW-1:0]),
    .wdata_i(req_i.wr_rgb),
    .re_i   (req_i.rd_en),
    .raddr_i(req_i.rd_slot[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (req_i.wr_en && wr_in_range) begin
        valid_q[req_i.wr_slot[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_ok_q <= rd_in_range && valid_q[req_i.rd_slot[AW-1:0]];
      end
    end
  end

  assign rgb_o = rd_ok_q ? ram_rdata : '0;

endmodule

`default_nettype wire

/* src/palrle_ctrl.sv */
// run decoder: parses control and data bytes, issues palette writes and reads, drives result register
// depends on palrle_pkg
`default_nettype none

module palrle_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire palrle_pkg::in_item_t  in_data_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  output palrle_pkg::out_item_t      out_data_o,
  input  wire logic                  out_ready_i,
  input  wire logic                  cfg_valid_i,
  input  wire palrle_pkg::cfg_word_t cfg_data_i,
  output logic                       cfg_ready_o,
  output palrle_pkg::pal_req_t       pal_req_o,
  input  wire logic [palrle_pkg::RGB_W-1:0] pal_rgb_i
);
  import palrle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ZRUN,
    ST_CUT
  } state_e;

  state_e    state_q, state_d;
  mode_e     run_mode_q, run_mode_d;
  logic [5:0] run_left_q, run_left_d;
  logic      pair_phase_q, pair_phase_d;
  logic [7:0] held_index_q, held_index_d;
  logic [7:0] default_idx_q, default_idx_d;
  logic [5:0] zleft_q, zleft_d;
  logic      pend_cut_q, pend_cut_d;
  logic [7:0] alpha_q, alpha_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic accept;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [7:0] b;
    logic [5:0] cnt;
    logic [5:0] left_n;
    logic       pix;
    logic       cut;
    mode_e      mode;

    b      = in_data_i.stream_byte;
    cnt    = b[7:2];
    mode   = mode_e'(b[1:0]);
    left_n = run_left_q;
    pix    = 1'b0;
    cut    = 1'b0;

    state_d       = state_q;
    run_mode_d    = run_mode_q;
    run_left_d    = run_left_q;
    pair_phase_d  = pair_phase_q;
    held_index_d  = held_index_q;
    default_idx_d = default_idx_q;
    zleft_d       = zleft_q;
    pend_cut_d    = pend_cut_q;
    alpha_d       = alpha_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    pal_req_o     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      default_idx_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.operation == OP_LOAD) begin
            pal_req_o.wr_en   = 1'b1;
            pal_req_o.wr_slot = in_data_i.palette_slot;
            pal_req_o.wr_rgb  = {in_data_i.load_red, in_data_i.load_green,
                                 in_data_i.load_blue};
          end else begin
            if (run_left_q == '0) begin
              if (mode == MODE_CLEAR) begin
                if (cnt != '0) begin
                  zleft_d = cnt;
                  state_d = ST_ZRUN;
                end
              end else if (cnt != '0) begin
                run_mode_d   = mode;
                left_n       = cnt;
                pair_phase_d = 1'b0;
              end
            end else begin
              case (run_mode_q)
                MODE_INDEX: begin
                  pal_req_o.rd_slot = b;
                  alpha_d           = ALPHA_OPAQUE;
                  left_n            = run_left_q - 6'd1;
                  pix               = 1'b1;
                end
                MODE_PAIR: begin
                  if (!pair_phase_q) begin
                    held_index_d = b;
                    pair_phase_d = 1'b1;
                  end else begin
                    pal_req_o.rd_slot = held_index_q;
                    alpha_d           = b;
                    pair_phase_d      = 1'b0;
                    left_n            = run_left_q - 6'd1;
                    pix               = 1'b1;
                  end
                end
                default: begin
                  pal_req_o.rd_slot = default_idx_q;
                  alpha_d           = b;
                  left_n            = run_left_q - 6'd1;
                  pix               = 1'b1;
                end
              endcase
            end
            run_left_d = left_n;
            cut        = in_data_i.final_byte && (left_n != '0);
            pend_cut_d = cut;
            pal_req_o.rd_en = pix;
            if (in_data_i.final_byte) begin
              run_mode_d   = MODE_CLEAR;
              run_left_d   = '0;
              pair_phase_d = 1'b0;
              held_index_d = '0;
            end
            if (pix) begin
              state_d = ST_LOOKUP;
            end else if (cut) begin
              state_d = ST_CUT;
            end
          end
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = KIND_PIXEL;
          out_d.pixel_red   = pal_rgb_i[23:16];
          out_d.pixel_green = pal_rgb_i[15:8];
          out_d.pixel_blue  = pal_rgb_i[7:0];
          out_d.pixel_alpha = alpha_q;
          out_d.run_end     = !pend_cut_q;
          state_d           = pend_cut_q ? ST_CUT : ST_IDLE;
        end
      end
      ST_ZRUN: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = KIND_PIXEL;
          out_d.pixel_red   = '0;
          out_d.pixel_green = '0;
          out_d.pixel_blue  = '0;
          out_d.pixel_alpha = ALPHA_CLEAR;
          out_d.run_end     = (zleft_q == 6'd1);
          zleft_d           = zleft_q - 6'd1;
          if (zleft_q == 6'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = KIND_CUT;
          out_d.pixel_red   = '0;
          out_d.pixel_green = '0;
          out_d.pixel_blue  = '0;
          out_d.pixel_alpha = ALPHA_CLEAR;
          out_d.run_end     = 1'b1;
          pend_cut_d        = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      run_mode_q    <= MODE_CLEAR;
      run_left_q    <= '0;
      pair_phase_q  <= 1'b0;
      held_index_q  <= '0;
      default_idx_q <= '0;
      zleft_q       <= '0;
      pend_cut_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      run_mode_q    <= run_mode_d;
      run_left_q    <= run_left_d;
      pair_phase_q  <= pair_phase_d;
      held_index_q  <= held_index_d;
      default_idx_q <= default_idx_d;
      zleft_q       <= zleft_d;
      pend_cut_q    <= pend_cut_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    alpha_q <= alpha_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* src/palette_rle_pixel_decoder.sv */
// palette run-length pixel decoder, top level
// a data byte's pixel is read from the palette ram, then loaded into the output register when it is free
// loads and bytes without a pixel or cut leave the decoder idle; a byte with a pixel does one palette ram read;
// new beats wait while a pixel, a transparent run or a cut result is still going to the output register
// reset: run state and default index cleared, palette valid bits cleared so entries read black
// depends on palrle_pkg, palrle_chan_if, palrle_pal, palrle_ctrl
`default_nettype none

module palette_rle_pixel_decoder #(
  parameter int unsigned PALETTE_DEPTH = palrle_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  palrle_chan_if.sink    in_i,
  palrle_chan_if.source  out_o,
  palrle_chan_if.sink    cfg_i
);
  import palrle_pkg::*;

  pal_req_t         pal_req;
  logic [RGB_W-1:0] pal_rgb;

  palrle_pal #(
    .DEPTH(PALETTE_DEPTH)
  ) u_pal (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (pal_req),
    .rgb_o (pal_rgb)
  );

  palrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_data_o (out_o.data),
    .out_ready_i(out_o.ready),
    .cfg_valid_i(cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .cfg_ready_o(cfg_i.ready),
    .pal_req_o  (pal_req),
    .pal_rgb_i  (pal_rgb)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for palette_rle_pixel_decoder: directed table, then random image streams
// expected pixels come from a behavioral decoder kept inside this file
// depends on palrle_pkg, palrle_chan_if and the decoder rtl
`timescale 1ns / 100ps

module tb;
  import palrle_pkg::*;

  localparam int unsigned PAL_DEPTH = PALETTE_DEPTH_DEF;
  localparam int PREDICT = -1;
  localparam out_item_t PX_CLEAR = '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, ALPHA_CLEAR, 1'b0};
  localparam out_item_t PX_BLACK = '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b0};
  localparam out_item_t PX_CUT   = '{KIND_CUT, 8'h00, 8'h00, 8'h00, ALPHA_CLEAR, 1'b0};

  typedef struct packed {
    in_item_t  beat;
    int        fixed_n;
    out_item_t fixed;
  } stim_row_t;

  logic clk;
  logic rst_n;

  palrle_chan_if #(.data_t(in_item_t))  in_ch ();
  palrle_chan_if #(.data_t(out_item_t)) out_ch ();
  palrle_chan_if #(.data_t(cfg_word_t)) cfg_ch ();

  palette_rle_pixel_decoder #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // decoder state
  logic [23:0] pal_mem [PAL_DEPTH];
  cfg_word_t   dflt_idx;
  mode_e       cur_mode;
  logic [5:0]  runs_left;
  logic        pair_half;
  logic [7:0]  held_idx;

  out_item_t   step_px [$];
  out_item_t   px_expect_q [$];
  stim_row_t   dir_tab [$];
  int          bad_cnt;
  logic        steady;
  int          hold_ask;
  int          hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [23:0] pal_read(logic [7:0] idx);
    if (idx < PAL_DEPTH) return pal_mem[idx];
    return 24'h000000;
  endfunction

  function automatic void add_px(kind_e k, logic [23:0] rgb, logic [7:0] a);
    out_item_t r;
    r = '{k, rgb[23:16], rgb[15:8], rgb[7:0], a, 1'b0};
    step_px.insert(step_px.size(), r);
  endfunction

  function automatic void decode_beat(in_item_t b);
    out_item_t  r;
    mode_e      md;
    logic [5:0] cnt;
    step_px.delete();
    if (b.operation == OP_LOAD) begin
      if (b.palette_slot < PAL_DEPTH)
        pal_mem[b.palette_slot] = {b.load_red, b.load_green, b.load_blue};
      return;
    end
    md  = mode_e'(b.stream_byte[1:0]);
    cnt = b.stream_byte[7:2];
    if (runs_left == 6'd0) begin
      if (md == MODE_CLEAR) begin
        repeat (cnt) add_px(KIND_PIXEL, 24'h000000, ALPHA_CLEAR);
      end else if (cnt != 6'd0) begin
        cur_mode  = md;
        runs_left = cnt;
        pair_half = 1'b0;
      end
    end else begin
      case (cur_mode)
        MODE_INDEX: begin
          add_px(KIND_PIXEL, pal_read(b.stream_byte), ALPHA_OPAQUE);
          runs_left--;
        end
        MODE_PAIR: begin
          if (!pair_half) begin
            held_idx  = b.stream_byte;
            pair_half = 1'b1;
          end else begin
            add_px(KIND_PIXEL, pal_read(held_idx), b.stream_byte);
            pair_half = 1'b0;
            runs_left--;
          end
        end
        default: begin
          add_px(KIND_PIXEL, pal_read(dflt_idx), b.stream_byte);
          runs_left--;
        end
      endcase
    end
    if (b.final_byte) begin
      if (runs_left != 6'd0) add_px(KIND_CUT, 24'h000000, ALPHA_CLEAR);
      cur_mode  = MODE_CLEAR;
      runs_left = 6'd0;
      pair_half = 1'b0;
      held_idx  = 8'h00;
    end
    if (step_px.size() != 0) begin
      r = step_px[step_px.size() - 1];
      r.run_end = 1'b1;
      step_px[step_px.size() - 1] = r;
    end
  endfunction

  function automatic stim_row_t sb(logic [7:0] byt, logic fin, int n, out_item_t px);
    stim_row_t   row;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    row.beat = raw[$bits(in_item_t)-1:0];
    row.beat.operation   = OP_STREAM;
    row.beat.stream_byte = byt;
    row.beat.final_byte  = fin;
    row.fixed_n = n;
    row.fixed   = px;
    return row;
  endfunction

  function automatic stim_row_t ld(logic [7:0] slot, logic [23:0] rgb);
    stim_row_t row;
    row = sb(8'($urandom), 1'($urandom), 0, PX_CLEAR);
    row.beat.operation = OP_LOAD;
    row.beat.palette_slot = slot;
    {row.beat.load_red, row.beat.load_green, row.beat.load_blue} = rgb;
    return row;
  endfunction

  // mostly well-formed image streams, some noise
  function automatic stim_row_t pick_beat();
    stim_row_t   row;
    mode_e       md;
    logic [5:0]  cnt;
    int unsigned roll;
    logic        need_idx;
    logic        last;
    row = sb(8'($urandom), 1'b0, PREDICT, PX_CLEAR);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      row.beat.operation  = 1'($urandom);
      row.beat.final_byte = ($urandom_range(0, 3) == 0);
    end else if (roll < 22) begin
      row.beat.operation  = OP_LOAD;
      row.beat.final_byte = 1'($urandom);
      if ($urandom_range(0, 3) != 0) row.beat.palette_slot = 8'($urandom_range(0, 15));
    end else if (runs_left == 6'd0) begin
      md   = mode_e'(2'($urandom_range(0, 3)));
      roll = $urandom_range(0, 19);
      if (roll == 0) cnt = 6'd0;
      else if (roll == 1 && md == MODE_CLEAR) cnt = 6'd63;
      else if (roll < 4) cnt = (md == MODE_CLEAR) ? 6'($urandom) : 6'($urandom_range(5, 16));
      else cnt = 6'($urandom_range(1, 4));
      row.beat.stream_byte = {cnt, md};
      row.beat.final_byte  = ($urandom_range(0, 19) == 0);
    end else begin
      need_idx = (cur_mode == MODE_INDEX) || (cur_mode == MODE_PAIR && !pair_half);
      if (need_idx && $urandom_range(0, 3) != 0)
        row.beat.stream_byte = 8'($urandom_range(0, 15));
      else if (!need_idx && $urandom_range(0, 3) == 0)
        row.beat.stream_byte = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      last = (runs_left == 6'd1) && (cur_mode != MODE_PAIR || pair_half);
      row.beat.final_byte = last ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 29) == 0);
    end
    return row;
  endfunction

  task automatic send_beat(input stim_row_t row);
    out_item_t r;
    @(negedge clk);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.data  = row.beat;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_beat(row.beat);
    if (row.fixed_n == PREDICT) begin
      foreach (step_px[k]) px_expect_q.insert(px_expect_q.size(), step_px[k]);
    end else begin
      for (int k = 0; k < row.fixed_n; k++) begin
        r = row.fixed;
        r.run_end = (k == row.fixed_n - 1);
        px_expect_q.insert(px_expect_q.size(), r);
      end
    end
  endtask

  task automatic set_default_index(input cfg_word_t v);
    @(negedge clk);
    cfg_ch.data  = v;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    dflt_idx = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (px_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (bad_cnt < 10) $display("mismatch %s: expected %h got %h", name, want, got);
      bad_cnt++;
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_ask != hold_done) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_done++;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_out
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (px_expect_q.size() == 0) begin
        if (bad_cnt < 10) $display("unexpected beat %h", got);
        bad_cnt++;
      end else begin
        want = px_expect_q.pop_front();
        cmp_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
        cmp_field("pixel_red", want.pixel_red, got.pixel_red);
        cmp_field("pixel_green", want.pixel_green, got.pixel_green);
        cmp_field("pixel_blue", want.pixel_blue, got.pixel_blue);
        cmp_field("pixel_alpha", want.pixel_alpha, got.pixel_alpha);
        cmp_field("run_end", 8'(want.run_end), 8'(got.run_end));
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    bad_cnt      = 0;
    steady       = 1'b0;
    hold_ask     = 0;
    foreach (pal_mem[i]) pal_mem[i] = 24'h000000;
    dflt_idx  = 8'h00;
    cur_mode  = MODE_CLEAR;
    runs_left = 6'd0;
    pair_half = 1'b0;
    held_idx  = 8'h00;

    dir_tab = '{
      sb(8'h00, 1'b0, 0, PX_CLEAR),
      sb(8'hFC, 1'b0, 63, PX_CLEAR),
      sb(8'h05, 1'b0, 0, PX_CLEAR),
      sb(8'h07, 1'b0, 1, PX_BLACK),
      ld(8'h00, 24'hFFFFFF),
      ld(8'hFF, 24'hA5C3E7),
      sb(8'h09, 1'b0, 0, PX_CLEAR),
      sb(8'hFF, 1'b0, PREDICT, PX_CLEAR),
      ld(8'h80, 24'h5A3C0F),
      sb(8'h80, 1'b0, PREDICT, PX_CLEAR),
      sb(8'h06, 1'b0, 0, PX_CLEAR),
      sb(8'h00, 1'b0, 0, PX_CLEAR),
      sb(8'h00, 1'b0, PREDICT, PX_CLEAR),
      sb(8'h03, 1'b0, 0, PX_CLEAR),
      sb(8'hFF, 1'b0, 0, PX_CLEAR),
      sb(8'hFF, 1'b1, PREDICT, PX_CLEAR),
      sb(8'h01, 1'b1, 0, PX_CLEAR),
      sb(8'h0A, 1'b1, 1, PX_CUT),
      sb(8'h08, 1'b1, 2, PX_CLEAR),
      sb(8'h0E, 1'b0, 0, PX_CLEAR),
      sb(8'hFF, 1'b1, 1, PX_CUT),
      sb(8'hFD, 1'b0, 0, PX_CLEAR),
      sb(8'h42, 1'b1, PREDICT, PX_CLEAR)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    drain_all();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_default_index(8'hFF);
        1: set_default_index(8'h00);
        default: set_default_index(cfg_word_t'($urandom_range(0, 255)));
      endcase
      if (ph == 2) begin
        // receiver stops while long transparent runs pile up
        hold_ask++;
        send_beat(sb(8'h00, 1'b1, PREDICT, PX_CLEAR));
        repeat (3) send_beat(sb(8'hFC, 1'b0, PREDICT, PX_CLEAR));
      end
      if (ph == 5) steady = 1'b1;
      repeat (22) send_beat(pick_beat());
      drain_all();
    end

    if (bad_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/palrle_pkg.sv
src/palrle_chan_if.sv
src/palrle_ram.sv
src/palrle_pal.sv
src/palrle_ctrl.sv
src/palette_rle_pixel_decoder.sv
test/tb.sv
